// ===== rtl/core/dbcr_pkg.sv =====
// Package with constants, command codes and helper functions of the detector bus responder.
package dbcr_pkg;
  localparam int ADC_BITS = 12;
  localparam int GROUP_SIZE = 18;

  localparam logic [6:0] CMD_PATROL = 7'h01;
  localparam logic [6:0] CMD_ALM_PATROL = 7'h08;
  localparam logic [6:0] CMD_VERIFY = 7'h16;
  localparam logic [6:0] CMD_GRP_POLL = 7'h06;
  localparam logic [6:0] CMD_FAULT = 7'h18;
  localparam logic [6:0] CMD_TEST = 7'h10;
  localparam logic [6:0] CMD_ENC = 7'h2f;
  localparam logic [6:0] CMD_SETADDR = 7'h55;
  localparam logic [6:0] CMD_RD_MODE = 7'h2b;
  localparam logic [6:0] CMD_WM0 = 7'h51;
  localparam logic [6:0] CMD_WM1 = 7'h54;
  localparam logic [6:0] CMD_WM2 = 7'h5a;
  localparam logic [6:0] CMD_RD_CAL = 7'h2c;
  localparam logic [6:0] CMD_BKG = 7'h69;
  localparam logic [6:0] CMD_ALM0 = 7'h62;
  localparam logic [6:0] CMD_ALM1 = 7'h64;
  localparam logic [6:0] CMD_ALM2 = 7'h66;
  localparam logic [6:0] CMD_DIFF = 7'h26;
  localparam logic [6:0] CMD_MASK = 7'h13;
  localparam logic [6:0] CMD_SAMPLE = 7'h38;

  localparam logic [8:0] GLOBAL_ADDR = 9'h1f5;
  localparam logic [8:0] ENC_READ = 9'h055;
  localparam logic [8:0] ENC_ARM = 9'h0aa;
  localparam logic [8:0] ADDR_LIMIT = 9'd325;
  localparam logic [8:0] BKG_LOW = 9'h010;
  localparam logic [8:0] BKG_HIGH = 9'h050;
  localparam logic [17:0] RW_UNASSIGNED = 18'h001ff;
  localparam logic [17:0] RW_BKG_FAIL = 18'h0ff00;
  localparam logic [17:0] RW_ALM_FAIL = 18'h000ff;
  localparam logic [17:0] RW_MASK = 18'h05a00;
  localparam logic [4:0] ALARM_LIMIT = 5'd20;
  localparam logic [1:0] PATROL_LIMIT = 2'd3;

  localparam int FL_EN1 = 0;
  localparam int FL_EN2 = 1;
  localparam int FL_WM = 2;
  localparam int FL_BK = 3;
  localparam int FL_SBK = 4;
  localparam int FL_ALM = 5;
  localparam int FL_SALM = 6;
  localparam int FL_MASK = 7;

  localparam logic [2:0] CFG_GROUP = 3'd0;
  localparam logic [2:0] CFG_POS = 3'd1;
  localparam logic [2:0] CFG_ASSIGNED = 3'd2;
  localparam logic [2:0] CFG_MODE = 3'd3;
  localparam logic [2:0] CFG_BKG = 3'd4;
  localparam logic [2:0] CFG_ALARM = 3'd5;

  localparam logic [2:0] NVT_ADDR = 3'd0;
  localparam logic [2:0] NVT_MODE = 3'd1;
  localparam logic [2:0] NVT_BKG = 3'd2;
  localparam logic [2:0] NVT_ALM = 3'd3;

  typedef struct packed {
    logic [4:0] group_number;
    logic [4:0] position_in_group;
    logic       address_assigned;
    logic [1:0] stored_work_mode;
    logic [7:0] stored_background;
    logic [7:0] stored_alarm_level;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  frame_command;
    logic [8:0]  frame_address;
    logic [1:0]  sensor_condition;
    logic        polluted;
    logic [5:0]  detector_level;
    logic [7:0]  filtered_level;
    logic [7:0]  tracked_background;
    logic [ADC_BITS-1:0] raw_sample;
  } req_t;

  typedef struct packed {
    logic        reply_valid;
    logic [17:0] reply_word;
    logic        led_on;
    logic        sample_now;
    logic        nv_write;
    logic [2:0]  nv_target;
    logic [8:0]  nv_value;
    logic        soft_reset;
    logic        log_alarm_req;
    logic        log_alarm_confirm;
    logic        alarm_int_disabled;
    logic [7:0]  alarm_verify_count;
  } rsp_t;

  function automatic logic [17:0] status_word(input logic [3:0] st, input logic [5:0] lvl);
    logic [17:0] w;
    w = 18'h00800 | ({16'd0, st[3:2]} << 8) | ({14'd0, st} << 6) | {12'd0, lvl};
    return w;
  endfunction

  function automatic logic [17:0] checked_byte(input logic [7:0] v);
    return {2'b00, v, ~v};
  endfunction
endpackage

// ===== rtl/core/dbcr_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface dbcr_req_if import dbcr_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dbcr_rsp_if import dbcr_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/detector_bus_command_responder.sv =====
// Top level of the detector bus command responder.
// The in_ channel carries one decoded bus frame with the sensor status per request.
// The out_ channel returns exactly one result per request: an optional reply word
// plus LED, sample, memory-write, soft-reset and logging requests.
// The cfg_ port is an APB-style register file holding the node identity and the
// calibration values read from memory; write it only while the block is idle.
// A request is registered at the input and decoded in a single pass into the
// output register. Throughput is one request per cycle while the receiver does not
// stall, set by the single decode stage.
// When the receiver stalls, the output register holds its result, the input
// register fills, and in_ready falls until out_ready returns.
// Reset empties both pipeline registers, clears the handshake flags, reloads the
// alarm and patrol counters and returns the registers to group one, position one.
module detector_bus_command_responder import dbcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dbcr_req_if.sink    in_ch,
  dbcr_rsp_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  cfg_t cfg;
  req_t rq_r;
  logic rq_vld_r;
  rsp_t rsp, rsp_r;
  logic rsp_vld_r;
  logic adv;
  logic [15:0] node;

  dbcr_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  assign node = 16'(({11'd0, cfg.group_number} - 16'd1) * 16'(GROUP_SIZE)
                + {11'd0, cfg.position_in_group});
  assign adv = rq_vld_r && (!rsp_vld_r || out_ch.ready);
  assign in_ch.ready = !rq_vld_r || adv;

  dbcr_core u_core (
    .clk, .rst_n, .fire_in(adv), .rq(rq_r), .cfg, .node, .rsp
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_vld_r <= 1'b0; rsp_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) rq_vld_r <= in_ch.valid;
      if (adv) rsp_vld_r <= 1'b1;
      else if (out_ch.ready) rsp_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) rq_r <= in_ch.data;
    if (adv) rsp_r <= rsp;
  end

  assign out_ch.valid = rsp_vld_r;
  assign out_ch.data = rsp_r;
endmodule

// ===== rtl/core/dbcr_cfg.sv =====
// APB-style configuration register file.
module dbcr_cfg import dbcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);
  cfg_t cfg_r;
  logic [2:0] idx;
  logic wr;

  assign idx = cfg_paddr[4:2];
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{group_number: 5'd1, position_in_group: 5'd1, default: '0};
    end else if (wr) begin
      case (idx)
        CFG_GROUP: cfg_r.group_number <= cfg_pwdata[4:0];
        CFG_POS: cfg_r.position_in_group <= cfg_pwdata[4:0];
        CFG_ASSIGNED: cfg_r.address_assigned <= cfg_pwdata[0];
        CFG_MODE: cfg_r.stored_work_mode <= cfg_pwdata[1:0];
        CFG_BKG: cfg_r.stored_background <= cfg_pwdata[7:0];
        CFG_ALARM: cfg_r.stored_alarm_level <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_GROUP: cfg_prdata = {27'd0, cfg_r.group_number};
      CFG_POS: cfg_prdata = {27'd0, cfg_r.position_in_group};
      CFG_ASSIGNED: cfg_prdata = {31'd0, cfg_r.address_assigned};
      CFG_MODE: cfg_prdata = {30'd0, cfg_r.stored_work_mode};
      CFG_BKG: cfg_prdata = {24'd0, cfg_r.stored_background};
      CFG_ALARM: cfg_prdata = {24'd0, cfg_r.stored_alarm_level};
      default: cfg_prdata = '0;
    endcase
  end
endmodule

// ===== rtl/core/dbcr_core.sv =====
// Command decode, protocol state and result encoding for one request.
module dbcr_core import dbcr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic fire_in,
  input  req_t rq,
  input  cfg_t cfg,
  input  logic [15:0] node,
  output rsp_t rsp
);
  logic [7:0] flags_r, flags_nxt;
  logic [8:0] saddr_r, saddr_nxt;
  logic [1:0] ssel_r, ssel_nxt;
  logic [4:0] areq_r, areq_nxt;
  logic [1:0] npat_r, npat_nxt;
  logic       mark_r, mark_nxt;
  logic [7:0] vcnt_r, vcnt_nxt;

  logic [3:0] st;
  logic node_hit, grp_hit, fire, err, pol;
  logic [17:0] bitmap;
  logic [1:0] sel;
  logic [7:0] diff;

  always_comb begin
    pol = rq.polluted;
    err = rq.sensor_condition == 2'd1;
    fire = rq.sensor_condition == 2'd2;
    node_hit = {7'd0, rq.frame_address} == node;
    grp_hit = rq.frame_address == {4'd0, cfg.group_number};
    if (pol) st = 4'd5;
    else if (err) st = 4'd4;
    else if (fire) st = 4'd7;
    else if (cfg.stored_work_mode != 2'd3) st = {2'b00, cfg.stored_work_mode} + 4'd1;
    else st = 4'd1;
    if (cfg.position_in_group >= 5'd1 &&
        cfg.position_in_group <= 5'(GROUP_SIZE))
      bitmap = 18'd1 << (5'(GROUP_SIZE) - cfg.position_in_group);
    else
      bitmap = '0;
    diff = rq.tracked_background - cfg.stored_background;
    case (rq.frame_command)
      CMD_WM0, CMD_ALM0: sel = 2'd0;
      CMD_WM1, CMD_ALM1: sel = 2'd1;
      default: sel = 2'd2;
    endcase
  end

  always_comb begin
    flags_nxt = flags_r; saddr_nxt = saddr_r; ssel_nxt = ssel_r;
    areq_nxt = areq_r; npat_nxt = npat_r; mark_nxt = mark_r; vcnt_nxt = vcnt_r;
    rsp = '0;
    case (rq.frame_command)
      CMD_PATROL: if (node_hit) begin
        rsp.reply_valid = 1'b1; rsp.reply_word = status_word(st, rq.detector_level);
        rsp.sample_now = 1'b1;
        if (fire && !mark_r) begin
          if (areq_r > 5'd1) areq_nxt = areq_r - 5'd1;
          else begin
            areq_nxt = '0; mark_nxt = 1'b1;
          end
          rsp.log_alarm_req = 1'b1;
        end else if (npat_r <= 2'd1) begin
          npat_nxt = PATROL_LIMIT; areq_nxt = ALARM_LIMIT;
        end else npat_nxt = npat_r - 2'd1;
      end
      CMD_ALM_PATROL: begin
        if (grp_hit && fire) begin
          rsp.reply_valid = 1'b1; rsp.reply_word = bitmap;
        end
        vcnt_nxt = '0;
      end
      CMD_VERIFY: if (node_hit) begin
        rsp.led_on = 1'b1;
        if (vcnt_r != 8'hff) vcnt_nxt = vcnt_r + 8'd1;
        mark_nxt = 1'b1; rsp.log_alarm_confirm = 1'b1;
        rsp.reply_valid = 1'b1; rsp.reply_word = status_word(4'hf, rq.detector_level);
      end
      CMD_GRP_POLL: if (grp_hit && !err && !pol) begin
        rsp.reply_valid = 1'b1; rsp.reply_word = bitmap;
      end
      CMD_FAULT: if (node_hit) begin
        if (err) begin
          rsp.reply_valid = 1'b1; rsp.reply_word = status_word(4'hc, rq.detector_level);
        end else if (pol) begin
          rsp.reply_valid = 1'b1; rsp.reply_word = status_word(4'hd, rq.detector_level);
        end
      end
      CMD_TEST: if (node_hit) begin
        rsp.sample_now = 1'b1; mark_nxt = 1'b1; rsp.led_on = 1'b1;
        rsp.reply_valid = 1'b1; rsp.reply_word = status_word(st, rq.detector_level);
      end
      CMD_ENC: begin
        flags_nxt = '0;
        if (rq.frame_address == ENC_READ) begin
          rsp.led_on = 1'b1; rsp.reply_valid = 1'b1;
          if (!cfg.address_assigned) rsp.reply_word = RW_UNASSIGNED;
          else rsp.reply_word = {node, 2'b10} | {17'd0, ^node};
        end else if (rq.frame_address == ENC_ARM) flags_nxt[FL_EN1] = 1'b1;
      end
      CMD_SETADDR: begin
        if (!flags_r[FL_EN2]) begin
          if (flags_r[FL_EN1]) begin
            flags_nxt[FL_EN1] = 1'b0; flags_nxt[FL_EN2] = 1'b1;
            if (rq.frame_address >= 9'd1 && rq.frame_address < ADDR_LIMIT)
              saddr_nxt = rq.frame_address;
            else rsp.soft_reset = 1'b1;
          end
        end else begin
          flags_nxt[FL_EN2] = 1'b0;
          if (rq.frame_address == saddr_r) begin
            rsp.nv_write = 1'b1; rsp.nv_target = NVT_ADDR; rsp.nv_value = saddr_r;
          end
          rsp.soft_reset = 1'b1;
        end
      end
      CMD_RD_MODE: begin
        rsp.reply_valid = 1'b1; rsp.reply_word = checked_byte({6'd0, cfg.stored_work_mode});
      end
      CMD_WM0, CMD_WM1, CMD_WM2: begin
        if (!flags_r[FL_WM]) begin
          if (rq.frame_address == GLOBAL_ADDR || node_hit) begin
            flags_nxt[FL_WM] = 1'b1; ssel_nxt = sel;
            if (rq.frame_address != GLOBAL_ADDR) begin
              rsp.reply_valid = 1'b1; rsp.reply_word = checked_byte({6'd0, sel});
            end
          end
        end else begin
          flags_nxt[FL_WM] = 1'b0;
          if (ssel_r == sel) begin
            rsp.nv_write = 1'b1; rsp.nv_target = NVT_MODE;
            rsp.nv_value = {7'd0, sel}; rsp.soft_reset = 1'b1;
          end
        end
      end
      CMD_RD_CAL: begin
        rsp.reply_valid = 1'b1;
        rsp.reply_word = {2'b00, cfg.stored_background, cfg.stored_alarm_level};
      end
      CMD_BKG: begin
        if (rq.frame_address == GLOBAL_ADDR) begin
          if (!flags_r[FL_BK]) flags_nxt[FL_BK] = 1'b1;
          else begin
            flags_nxt[FL_BK] = 1'b0;
            if ({1'b0, rq.filtered_level} >= BKG_LOW && {1'b0, rq.filtered_level} <= BKG_HIGH)
            begin
              rsp.nv_write = 1'b1; rsp.nv_target = NVT_BKG;
              rsp.nv_value = {1'b0, rq.filtered_level}; rsp.soft_reset = 1'b1;
            end else begin
              rsp.reply_valid = 1'b1; rsp.reply_word = RW_BKG_FAIL;
            end
          end
        end else if (!flags_r[FL_SBK]) begin
          if (node_hit) begin
            flags_nxt[FL_SBK] = 1'b1;
            rsp.reply_valid = 1'b1; rsp.reply_word = checked_byte(rq.filtered_level);
          end
        end else begin
          flags_nxt[FL_SBK] = 1'b0;
          if (rq.frame_address >= BKG_LOW && rq.frame_address <= BKG_HIGH) begin
            rsp.nv_write = 1'b1; rsp.nv_target = NVT_BKG;
            rsp.nv_value = rq.frame_address; rsp.soft_reset = 1'b1;
          end else begin
            rsp.reply_valid = 1'b1; rsp.reply_word = RW_BKG_FAIL;
          end
        end
      end
      CMD_ALM0, CMD_ALM1, CMD_ALM2: begin
        if (rq.frame_address == GLOBAL_ADDR) begin
          if (!flags_r[FL_ALM]) begin
            flags_nxt[FL_ALM] = 1'b1; ssel_nxt = sel;
          end else begin
            flags_nxt[FL_ALM] = 1'b0;
            if (rq.filtered_level > rq.tracked_background && ssel_r == sel) begin
              rsp.nv_write = 1'b1; rsp.nv_target = NVT_ALM + {1'b0, sel};
              rsp.nv_value = {1'b0, rq.filtered_level}; rsp.soft_reset = 1'b1;
            end else begin
              rsp.reply_valid = 1'b1; rsp.reply_word = RW_ALM_FAIL;
            end
          end
        end else if (!flags_r[FL_SALM]) begin
          if (node_hit) begin
            flags_nxt[FL_SALM] = 1'b1; ssel_nxt = sel;
            rsp.reply_valid = 1'b1; rsp.reply_word = checked_byte(rq.filtered_level);
          end
        end else begin
          flags_nxt[FL_SALM] = 1'b0;
          if (rq.frame_address > {1'b0, rq.tracked_background} && ssel_r == sel) begin
            rsp.nv_write = 1'b1; rsp.nv_target = NVT_ALM + {1'b0, sel};
            rsp.nv_value = rq.frame_address; rsp.soft_reset = 1'b1;
          end else begin
            rsp.reply_valid = 1'b1; rsp.reply_word = RW_ALM_FAIL;
          end
        end
      end
      CMD_DIFF: if (rq.tracked_background > cfg.stored_background) begin
        rsp.reply_valid = 1'b1; rsp.reply_word = checked_byte(diff);
      end
      CMD_MASK: begin
        rsp.reply_valid = 1'b1;
        rsp.reply_word = flags_r[FL_MASK] ? 18'd0 : RW_MASK;
        flags_nxt[FL_MASK] = 1'b1; mark_nxt = 1'b1;
      end
      CMD_SAMPLE: begin
        rsp.sample_now = 1'b1; rsp.reply_valid = 1'b1;
        rsp.reply_word = checked_byte(rq.raw_sample[ADC_BITS-1 -: 8]);
      end
      default: ;
    endcase
    rsp.alarm_int_disabled = mark_nxt;
    rsp.alarm_verify_count = vcnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0; saddr_r <= '0; ssel_r <= '0;
      areq_r <= ALARM_LIMIT; npat_r <= PATROL_LIMIT; mark_r <= 1'b0; vcnt_r <= '0;
    end else if (fire_in) begin
      flags_r <= flags_nxt; saddr_r <= saddr_nxt; ssel_r <= ssel_nxt;
      areq_r <= areq_nxt; npat_r <= npat_nxt; mark_r <= mark_nxt; vcnt_r <= vcnt_nxt;
    end
  end
endmodule

// ===== rtl/core/dbcr_checker.sv =====
// Port-level assertions for the detector bus responder and their bind.
module dbcr_checker import dbcr_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_nv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.nv_write |-> out_data.nv_target == 3'd0 && out_data.nv_value == 9'd0)
    else $error("memory write fields set without a write");
  a_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reply_valid |-> out_data.reply_word == 18'd0)
    else $error("reply word set without a reply");
  a_nv_sreset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.nv_write |-> out_data.soft_reset)
    else $error("memory write without soft reset");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");
endmodule

bind detector_bus_command_responder dbcr_checker u_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
